/* rtl/core/gvns_pkg.sv */
package gvns_pkg;

    localparam int MAX_VERTICES_DEF = 8192;
    localparam int POS_WIDTH_DEF    = 24;

    localparam int IDX_W   = 13;
    localparam int CFG_W   = 14;
    localparam int FIELD_W = 24;
    localparam int NRM_W   = 16;
    localparam int SLOPE_W = 15;
    localparam int T_W     = 18;   // unit output, holds +/-2^16
    localparam int VEC_W   = 64;   // unitizer input

    localparam logic [CFG_W-1:0] ROW_LENGTH_RST   = 14'd65;
    localparam logic [CFG_W-1:0] VERTEX_COUNT_RST = 14'd4225;

    // register select, byte address bit 2
    localparam logic REG_ROW_LENGTH   = 1'b0;
    localparam logic REG_VERTEX_COUNT = 1'b1;

    typedef enum logic {
        ACT_STORE = 1'b0,
        ACT_QUERY = 1'b1
    } action_t;

    typedef struct packed {
        action_t                    action;
        logic [IDX_W-1:0]           index;
        logic signed [FIELD_W-1:0]  pos_x;
        logic signed [FIELD_W-1:0]  pos_y;
        logic signed [FIELD_W-1:0]  pos_z;
    } in_item_t;

    typedef struct packed {
        logic [IDX_W-1:0]          vertex_index;
        logic signed [NRM_W-1:0]   normal_x;
        logic signed [NRM_W-1:0]   normal_y;
        logic signed [NRM_W-1:0]   normal_z;
        logic [SLOPE_W-1:0]        slope;
    } out_item_t;

    typedef struct packed {
        logic start;
        logic frac16;   // 1: 16 fraction bits, 0: 14
    } unit_req_t;

    typedef struct packed {
        logic done;
        logic nonzero;
    } unit_rsp_t;

    // neighbour offset codes
    typedef enum logic [2:0] {
        OFF_MN  = 3'd0,   // -N
        OFF_M1  = 3'd1,   // -1
        OFF_1MN = 3'd2,   // 1-N
        OFF_P1  = 3'd3,   // +1
        OFF_NM1 = 3'd4,   // N-1
        OFF_N   = 3'd5    // +N
    } off_code_t;

    function automatic off_code_t pair_code(input logic [2:0] k, input logic second);
        off_code_t c;
        case ({k, second})
            4'b000_0: c = OFF_MN;
            4'b000_1: c = OFF_M1;
            4'b001_0: c = OFF_1MN;
            4'b001_1: c = OFF_MN;
            4'b010_0: c = OFF_P1;
            4'b010_1: c = OFF_1MN;
            4'b011_0: c = OFF_M1;
            4'b011_1: c = OFF_MN;
            4'b100_0: c = OFF_NM1;
            4'b100_1: c = OFF_N;
            4'b101_0: c = OFF_N;
            4'b101_1: c = OFF_P1;
            default:  c = OFF_MN;
        endcase
        return c;
    endfunction

endpackage

/* rtl/core/gvns_unitize.sv */
module gvns_unitize
    import gvns_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  unit_req_t               req,
    input  logic signed [VEC_W-1:0] vec [3],
    output unit_rsp_t               rsp,
    output logic signed [T_W-1:0]   t [3]
);

    typedef enum logic [7:0] {
        U_IDLE = 8'b0000_0001,
        U_NORM = 8'b0000_0010,
        U_SQ   = 8'b0000_0100,
        U_ACC  = 8'b0000_1000,
        U_SQRT = 8'b0001_0000,
        U_DIVI = 8'b0010_0000,
        U_DIV  = 8'b0100_0000,
        U_DONE = 8'b1000_0000
    } ustate_t;

    ustate_t          state_reg, state_next;
    logic [63:0]      mag_reg [3];
    logic [2:0]       neg_reg;
    logic             frac16_reg;
    logic [1:0]       k_reg;
    logic [59:0]      prod_reg;
    logic [63:0]      ssum_reg;
    logic [63:0]      x_reg, r_reg, bit_reg;
    logic [4:0]       cnt_reg;
    logic [47:0]      num_reg;
    logic [32:0]      rem_reg;
    logic [16:0]      q_reg;
    logic             nz_reg;
    logic signed [T_W-1:0] t_reg [3];

    logic [63:0]      mag_in [3];
    logic             all_zero;
    logic             any_high;
    logic             any_b29;
    logic [63:0]      trial;
    logic [31:0]      len;
    logic [47:0]      num_init;
    logic [32:0]      rem_sh;
    logic [32:0]      rem_new;
    logic [16:0]      q_new;
    logic [16:0]      one_q;
    logic [16:0]      q_sat;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            mag_in[i] = vec[i][VEC_W-1] ? 64'(-vec[i]) : 64'(vec[i]);
        end
        all_zero = (mag_in[0] == '0) && (mag_in[1] == '0) && (mag_in[2] == '0);
        any_high = |(mag_reg[0][63:30] | mag_reg[1][63:30] | mag_reg[2][63:30]);
        any_b29  = mag_reg[0][29] | mag_reg[1][29] | mag_reg[2][29];
        trial    = r_reg + bit_reg;
        len      = r_reg[31:0];
        num_init = (48'(mag_reg[k_reg][29:0]) << (frac16_reg ? 16 : 14))
                 + 48'(len >> 1);
        rem_sh   = {rem_reg[31:0], num_reg[16]};
        if (rem_sh >= {1'b0, len}) begin
            rem_new = rem_sh - {1'b0, len};
            q_new   = {q_reg[15:0], 1'b1};
        end else begin
            rem_new = rem_sh;
            q_new   = {q_reg[15:0], 1'b0};
        end
        one_q = frac16_reg ? 17'h10000 : 17'h04000;
        q_sat = (q_new > one_q) ? one_q : q_new;
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            U_IDLE: if (req.start) state_next = all_zero ? U_DONE : U_NORM;
            U_NORM: if (!any_high && any_b29) state_next = U_SQ;
            U_SQ:   state_next = U_ACC;
            U_ACC:  state_next = (k_reg == 2'd2) ? U_SQRT : U_SQ;
            U_SQRT: if (cnt_reg == 5'd31) state_next = U_DIVI;
            U_DIVI: state_next = U_DIV;
            U_DIV: begin
                if (cnt_reg == 5'd16) state_next = (k_reg == 2'd2) ? U_DONE : U_DIVI;
            end
            U_DONE: state_next = U_IDLE;
            default: state_next = U_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= U_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            U_IDLE: begin
                if (req.start) begin
                    for (int i = 0; i < 3; i++) begin
                        mag_reg[i] <= mag_in[i];
                        neg_reg[i] <= vec[i][VEC_W-1];
                        t_reg[i]   <= '0;
                    end
                    frac16_reg <= req.frac16;
                    nz_reg     <= !all_zero;
                end
                k_reg    <= '0;
                ssum_reg <= '0;
            end
            U_NORM: begin
                // bring the largest magnitude into [2^29, 2^30), one bit a cycle
                for (int i = 0; i < 3; i++) begin
                    if (any_high) mag_reg[i] <= mag_reg[i] >> 1;
                    else if (!any_b29) mag_reg[i] <= mag_reg[i] << 1;
                end
            end
            U_SQ: begin
                prod_reg <= mag_reg[k_reg][29:0] * mag_reg[k_reg][29:0];
            end
            U_ACC: begin
                ssum_reg <= ssum_reg + 64'(prod_reg);
                x_reg    <= ssum_reg + 64'(prod_reg);
                r_reg    <= '0;
                bit_reg  <= 64'(1) << 62;
                cnt_reg  <= '0;
                k_reg    <= (k_reg == 2'd2) ? 2'd0 : k_reg + 2'd1;
            end
            U_SQRT: begin
                if (x_reg >= trial) begin
                    x_reg <= x_reg - trial;
                    r_reg <= (r_reg >> 1) + bit_reg;
                end else begin
                    r_reg <= r_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
                cnt_reg <= cnt_reg + 5'd1;
            end
            U_DIVI: begin
                // quotient stays below 2^17, so the top bits start as remainder
                num_reg <= num_init;
                rem_reg <= 33'(num_init[47:17]);
                q_reg   <= '0;
                cnt_reg <= '0;
            end
            U_DIV: begin
                rem_reg <= rem_new;
                q_reg   <= q_new;
                num_reg <= num_reg << 1;
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd16) begin
                    t_reg[k_reg] <= neg_reg[k_reg] ? -$signed(T_W'(q_sat))
                                                   : $signed(T_W'(q_sat));
                    k_reg <= k_reg + 2'd1;
                end
            end
            default: begin
            end
        endcase
    end

    assign rsp.done    = (state_reg == U_DONE);
    assign rsp.nonzero = nz_reg;
    assign t           = t_reg;

endmodule

/* rtl/core/grid_vertex_normal_slope_core.sv */
// Vertex normal and slope over a raster grid of positions held in an internal
// single-port RAM of MAX_VERTICES entries (x, y, z of POS_WIDTH bits each).
// A store request (action 0) writes one position into the RAM and returns
// nothing; indices at or above MAX_VERTICES are dropped. A query request
// (action 1) reads the vertex and, for each of six neighbour pairs whose
// indices fall in [0, min(vertex_count, MAX_VERTICES)), forms the triangle
// cross product on one shared multiplier (six products), and hands it to the
// iterative unitizer: bit-serial normalize shift, three squares, a 32-step
// square root and three 17-step divisions. The unit normals of the valid
// pairs with a nonzero cross product are summed and run through the same
// unitizer once more (Q14), which goes straight to done when the sum is zero.
// A skipped pair only passes through the pair check; the unitizer's serial
// normalize, root and divides take most of the time of a query.
// One request is in flight at a time; s_ready is low until the result has
// been taken. Never-written entries read back undefined. Registers:
// row_length at 0x0, vertex_count at 0x4; the user must write them only while
// the block is idle, which the block itself does not enforce.
module grid_vertex_normal_slope_core
    import gvns_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF,
    parameter int POS_WIDTH    = POS_WIDTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  in_item_t    s_data,

    output logic        m_valid,
    input  logic        m_ready,
    output out_item_t   m_data,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int PW         = POS_WIDTH;
    localparam int AW         = $clog2(MAX_VERTICES);
    localparam int EDGE_SHIFT = (PW > 30) ? PW - 30 : 0;
    localparam int EW         = PW + 1 - EDGE_SHIFT;   // edge component width
    localparam int PRW        = 2 * EW;                // product width
    localparam int CW         = 2 * EW + 1;            // cross component width
    localparam int IXW        = 19;                    // signed neighbour index
    localparam int SUM_W      = 21;
    localparam logic [17:0] MAXV = 18'(MAX_VERTICES);

    typedef enum logic [12:0] {
        S_IDLE   = 13'b0_0000_0000_0001,
        S_RD_P   = 13'b0_0000_0000_0010,
        S_WAIT_P = 13'b0_0000_0000_0100,
        S_PAIR   = 13'b0_0000_0000_1000,
        S_RD_A   = 13'b0_0000_0001_0000,
        S_RD_B   = 13'b0_0000_0010_0000,
        S_EDGE   = 13'b0_0000_0100_0000,
        S_MUL    = 13'b0_0000_1000_0000,
        S_USTART = 13'b0_0001_0000_0000,
        S_UWAIT  = 13'b0_0010_0000_0000,
        S_FSTART = 13'b0_0100_0000_0000,
        S_FWAIT  = 13'b0_1000_0000_0000,
        S_OUT    = 13'b1_0000_0000_0000
    } state_t;

    state_t                 state_reg, state_next;
    logic [CFG_W-1:0]       row_length_reg, vertex_count_reg;
    logic [IDX_W-1:0]       idx_reg;
    logic [2:0]             pair_reg;
    logic [3*PW-1:0]        p_reg;
    logic signed [EW-1:0]   u_reg [3];
    logic signed [EW-1:0]   v_reg [3];
    logic [2:0]             mul_cnt_reg;
    logic signed [PRW-1:0]  prod_reg, first_reg;
    logic signed [CW-1:0]   c_reg [3];
    logic signed [SUM_W-1:0] sum_reg [3];
    out_item_t              out_reg;

    logic [3*PW-1:0]        mem [MAX_VERTICES];
    logic [3*PW-1:0]        rd_data_reg;
    logic [AW-1:0]          mem_addr;
    logic                   mem_we;
    logic [3*PW-1:0]        mem_wdata;

    logic                   s_fire;
    logic                   cfg_we;
    logic [16:0]            s_idx_ext, idx_ext;
    logic signed [IXW-1:0]  ia, ib;
    logic [17:0]            limit;
    logic                   pair_ok;
    logic signed [EW-1:0]   opa, opb;
    logic [2:0]             mul_j;
    logic [1:0]             c_idx;

    unit_req_t              ureq;
    unit_rsp_t              ursp;
    logic signed [VEC_W-1:0] uvec [3];
    logic signed [T_W-1:0]  ut [3];
    logic signed [17:0]     slope_full;
    logic signed [17:0]     chk_slope;

    function automatic logic signed [IXW-1:0] off_val(input off_code_t c,
                                                      input logic [CFG_W-1:0] n);
        logic signed [IXW-1:0] ns;
        ns = $signed(IXW'(n));
        case (c)
            OFF_MN:  off_val = -ns;
            OFF_M1:  off_val = -IXW'(1);
            OFF_1MN: off_val = IXW'(1) - ns;
            OFF_P1:  off_val = IXW'(1);
            OFF_NM1: off_val = ns - IXW'(1);
            OFF_N:   off_val = ns;
            default: off_val = '0;
        endcase
    endfunction

    // a - p, truncated toward zero when the edge is narrowed
    function automatic logic signed [EW-1:0] edge_of(input logic [PW-1:0] a,
                                                     input logic [PW-1:0] p);
        logic signed [PW:0] d;
        logic [PW:0]        m;
        d = $signed({a[PW-1], a}) - $signed({p[PW-1], p});
        m = d[PW] ? (PW+1)'(-d) : (PW+1)'(d);
        m = m >> EDGE_SHIFT;
        edge_of = d[PW] ? -$signed(EW'(m)) : $signed(EW'(m));
    endfunction

    // ---------------- handshakes and config ----------------
    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = (state_reg == S_OUT);
    assign m_data  = out_reg;
    assign s_fire  = s_valid && s_ready;
    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite && pready;
    assign prdata  = (paddr[2] == REG_VERTEX_COUNT) ? 32'(vertex_count_reg)
                                                    : 32'(row_length_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_length_reg   <= ROW_LENGTH_RST;
            vertex_count_reg <= VERTEX_COUNT_RST;
        end else if (cfg_we) begin
            if (paddr[2] == REG_ROW_LENGTH) row_length_reg <= pwdata[CFG_W-1:0];
            else vertex_count_reg <= pwdata[CFG_W-1:0];
        end
    end

    // ---------------- neighbour addressing ----------------
    assign s_idx_ext = 17'(s_data.index);
    assign idx_ext   = 17'(idx_reg);
    assign limit     = (18'(vertex_count_reg) < MAXV) ? 18'(vertex_count_reg) : MAXV;
    assign ia = $signed(IXW'(idx_reg)) + off_val(pair_code(pair_reg, 1'b0), row_length_reg);
    assign ib = $signed(IXW'(idx_reg)) + off_val(pair_code(pair_reg, 1'b1), row_length_reg);
    assign pair_ok = !ia[IXW-1] && !ib[IXW-1]
                  && (18'(ia) < limit) && (18'(ib) < limit);

    // ---------------- vertex RAM ----------------
    always_comb begin
        case (state_reg)
            S_RD_P:  mem_addr = idx_ext[AW-1:0];
            S_RD_A:  mem_addr = ia[AW-1:0];
            S_RD_B:  mem_addr = ib[AW-1:0];
            default: mem_addr = s_idx_ext[AW-1:0];
        endcase
    end

    assign mem_we    = s_fire && (s_data.action == ACT_STORE) && (18'(s_data.index) < MAXV);
    assign mem_wdata = {PW'($unsigned(s_data.pos_z)), PW'($unsigned(s_data.pos_y)),
                        PW'($unsigned(s_data.pos_x))};

    always_ff @(posedge aclk) begin
        if (mem_we) mem[mem_addr] <= mem_wdata;
        rd_data_reg <= mem[mem_addr];
    end

    // ---------------- shared multiplier operands ----------------
    always_comb begin
        case (mul_cnt_reg)
            3'd0: begin opa = u_reg[1]; opb = v_reg[2]; end
            3'd1: begin opa = u_reg[2]; opb = v_reg[1]; end
            3'd2: begin opa = u_reg[2]; opb = v_reg[0]; end
            3'd3: begin opa = u_reg[0]; opb = v_reg[2]; end
            3'd4: begin opa = u_reg[0]; opb = v_reg[1]; end
            3'd5: begin opa = u_reg[1]; opb = v_reg[0]; end
            default: begin opa = '0; opb = '0; end
        endcase
    end
    assign mul_j = mul_cnt_reg - 3'd1;
    assign c_idx = 2'(mul_j >> 1);

    // ---------------- unitizer ----------------
    always_comb begin
        ureq.start  = (state_reg == S_USTART) || (state_reg == S_FSTART);
        ureq.frac16 = (state_reg == S_USTART);
        for (int i = 0; i < 3; i++) begin
            uvec[i] = (state_reg == S_FSTART) ? VEC_W'(sum_reg[i]) : VEC_W'(c_reg[i]);
        end
    end

    gvns_unitize u_unit (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (ureq),
        .vec     (uvec),
        .rsp     (ursp),
        .t       (ut)
    );

    assign slope_full = 18'sd16385 + 18'(ut[1]);

    // ---------------- sequencer ----------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_fire && s_data.action == ACT_QUERY) begin
                    state_next = (18'(s_data.index) < MAXV) ? S_RD_P : S_OUT;
                end
            end
            S_RD_P:   state_next = S_WAIT_P;
            S_WAIT_P: state_next = S_PAIR;
            S_PAIR: begin
                if (pair_ok) state_next = S_RD_A;
                else if (pair_reg == 3'd5) state_next = S_FSTART;
            end
            S_RD_A:   state_next = S_RD_B;
            S_RD_B:   state_next = S_EDGE;
            S_EDGE:   state_next = S_MUL;
            S_MUL:    if (mul_cnt_reg == 3'd6) state_next = S_USTART;
            S_USTART: state_next = S_UWAIT;
            S_UWAIT: begin
                if (ursp.done) state_next = (pair_reg == 3'd5) ? S_FSTART : S_PAIR;
            end
            S_FSTART: state_next = S_FWAIT;
            S_FWAIT:  if (ursp.done) state_next = S_OUT;
            S_OUT:    if (m_ready) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            pair_reg  <= '0;
        end else begin
            state_reg <= state_next;
            case (state_reg)
                S_IDLE:  pair_reg <= '0;
                S_PAIR:  if (!pair_ok && pair_reg != 3'd5) pair_reg <= pair_reg + 3'd1;
                S_UWAIT: if (ursp.done && pair_reg != 3'd5) pair_reg <= pair_reg + 3'd1;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            S_IDLE: begin
                idx_reg     <= s_data.index;
                mul_cnt_reg <= '0;
                for (int i = 0; i < 3; i++) sum_reg[i] <= '0;
                // out-of-range query: zero normal, slope one half
                out_reg.vertex_index <= s_data.index;
                out_reg.normal_x     <= '0;
                out_reg.normal_y     <= '0;
                out_reg.normal_z     <= '0;
                out_reg.slope        <= SLOPE_W'(15'd8192);
            end
            S_WAIT_P: p_reg <= rd_data_reg;
            S_RD_B: begin
                for (int i = 0; i < 3; i++) begin
                    u_reg[i] <= edge_of(rd_data_reg[i*PW +: PW], p_reg[i*PW +: PW]);
                end
                mul_cnt_reg <= '0;
            end
            S_EDGE: begin
                for (int i = 0; i < 3; i++) begin
                    v_reg[i] <= edge_of(rd_data_reg[i*PW +: PW], p_reg[i*PW +: PW]);
                end
            end
            S_MUL: begin
                if (mul_cnt_reg != 3'd6) prod_reg <= opa * opb;
                if (mul_cnt_reg != 3'd0) begin
                    if (!mul_j[0]) first_reg <= prod_reg;
                    else c_reg[c_idx] <= CW'(first_reg) - CW'(prod_reg);
                end
                mul_cnt_reg <= mul_cnt_reg + 3'd1;
            end
            S_UWAIT: begin
                if (ursp.done && ursp.nonzero) begin
                    for (int i = 0; i < 3; i++) sum_reg[i] <= sum_reg[i] + SUM_W'(ut[i]);
                end
            end
            S_FWAIT: begin
                if (ursp.done) begin
                    out_reg.vertex_index <= idx_reg;
                    out_reg.normal_x     <= NRM_W'(ut[0]);
                    out_reg.normal_y     <= NRM_W'(ut[1]);
                    out_reg.normal_z     <= NRM_W'(ut[2]);
                    out_reg.slope        <= slope_full[SLOPE_W:1];
                end
            end
            default: begin
            end
        endcase
    end

    // ---------------- checks ----------------
    assign chk_slope = 18'sd16385 + 18'(m_data.normal_y);

    ap_slope_matches_ny: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.slope == chk_slope[SLOPE_W:1]))
        else $error("slope does not follow normal_y");

    ap_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("request accepted while result pending");

    ap_pair_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pair_reg <= 3'd5)
        else $error("pair counter out of range");

    ap_unit_done_waited: assert property (@(posedge aclk) disable iff (!aresetn)
        ursp.done |-> (state_reg == S_UWAIT || state_reg == S_FWAIT))
        else $error("unitizer finished outside a wait state");

endmodule

/* dv/tb.sv */
module tb;
    import gvns_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int  STORE_DEPTH = 8192;
    localparam int  CYCLE_LIMIT = 6000000;
    localparam int  DRAIN_WAIT  = 200;  // covers a trailing store and any idle turn-around

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    in_item_t    s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    out_item_t   m_data;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // mirror of the vertex store plus a map of which entries hold real data
    longint     grid_pos [STORE_DEPTH][3];
    bit         grid_seen [STORE_DEPTH];
    int         cur_row_len;
    int         cur_vert_cnt;

    out_item_t  pending_normals[$];
    int         mismatch_cnt = 0;
    int         cycle_cnt = 0;
    bit         no_idle = 1'b0;   // set for a stretch with no gaps on either side

    always #2 aclk = ~aclk;

    grid_vertex_normal_slope_core DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // ---------------------------------------------------------------------
    // Normal predictor
    // ---------------------------------------------------------------------
    function automatic longint unsigned int_sqrt(input longint unsigned x);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Scale a vector to unit length with frac fraction bits; returns 0 for zero input.
    function automatic bit unit_scale(input longint c[3], input int frac, output longint o[3]);
        longint unsigned mag[3];
        longint unsigned mx, sq, len, q, one;
        mx = 0;
        sq = 0;
        one = 64'd1 << frac;
        for (int k = 0; k < 3; k++) begin
            mag[k] = (c[k] < 0) ? longint'(-c[k]) : longint'(c[k]);
            if (mag[k] > mx) mx = mag[k];
        end
        for (int k = 0; k < 3; k++) o[k] = 0;
        if (mx == 0) return 1'b0;
        while (mx >= (64'd1 << 30)) begin
            mx = mx >> 1;
            for (int k = 0; k < 3; k++) mag[k] = mag[k] >> 1;
        end
        while (mx < (64'd1 << 29)) begin
            mx = mx << 1;
            for (int k = 0; k < 3; k++) mag[k] = mag[k] << 1;
        end
        for (int k = 0; k < 3; k++) sq += mag[k] * mag[k];
        len = int_sqrt(sq);
        for (int k = 0; k < 3; k++) begin
            q = ((mag[k] << frac) + (len >> 1)) / len;
            if (q > one) q = one;
            o[k] = (c[k] < 0) ? -longint'(q) : longint'(q);
        end
        return 1'b1;
    endfunction

    // neighbour offset for each coded offset
    function automatic longint nbr_offset(input off_code_t oc);
        case (oc)
            OFF_MN:  return -longint'(cur_row_len);
            OFF_M1:  return -1;
            OFF_1MN: return 1 - longint'(cur_row_len);
            OFF_P1:  return 1;
            OFF_NM1: return longint'(cur_row_len) - 1;
            default: return longint'(cur_row_len);
        endcase
    endfunction

    function automatic longint nbr_limit();
        return (cur_vert_cnt < STORE_DEPTH) ? cur_vert_cnt : STORE_DEPTH;
    endfunction

    // a query may only touch entries that were written
    function automatic bit query_safe(input int idx);
        longint ia, ib;
        if (!grid_seen[idx]) return 1'b0;
        for (int k = 0; k < 6; k++) begin
            ia = idx + nbr_offset(pair_code(3'(k), 1'b0));
            ib = idx + nbr_offset(pair_code(3'(k), 1'b1));
            if (ia < 0 || ia >= nbr_limit() || ib < 0 || ib >= nbr_limit()) continue;
            if (!grid_seen[ia] || !grid_seen[ib]) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic out_item_t vertex_normal(input int idx);
        out_item_t r;
        longint sum[3], nrm[3], u[3], v[3], c[3], t[3];
        longint ia, ib;
        for (int j = 0; j < 3; j++) sum[j] = 0;
        for (int k = 0; k < 6; k++) begin
            ia = idx + nbr_offset(pair_code(3'(k), 1'b0));
            ib = idx + nbr_offset(pair_code(3'(k), 1'b1));
            if (ia < 0 || ia >= nbr_limit() || ib < 0 || ib >= nbr_limit()) continue;
            for (int j = 0; j < 3; j++) begin
                u[j] = grid_pos[ia][j] - grid_pos[idx][j];
                v[j] = grid_pos[ib][j] - grid_pos[idx][j];
            end
            c[0] = u[1] * v[2] - u[2] * v[1];
            c[1] = u[2] * v[0] - u[0] * v[2];
            c[2] = u[0] * v[1] - u[1] * v[0];
            if (unit_scale(c, 16, t))
                for (int j = 0; j < 3; j++) sum[j] += t[j];
        end
        void'(unit_scale(sum, 14, nrm));
        r.vertex_index = IDX_W'(idx);
        r.normal_x     = NRM_W'(nrm[0]);
        r.normal_y     = NRM_W'(nrm[1]);
        r.normal_z     = NRM_W'(nrm[2]);
        r.slope        = SLOPE_W'((16384 + nrm[1] + 1) >> 1);
        return r;
    endfunction

    // ---------------------------------------------------------------------
    // Request side
    // ---------------------------------------------------------------------
    task automatic send_request(input in_item_t it);
        if (!no_idle && $urandom_range(99) < 12) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        // accepted at this edge: update the mirror / queue the expected normal
        if (it.action == ACT_STORE) begin
            grid_pos[it.index][0] = longint'(it.pos_x);
            grid_pos[it.index][1] = longint'(it.pos_y);
            grid_pos[it.index][2] = longint'(it.pos_z);
            grid_seen[it.index]   = 1'b1;
        end else begin
            pending_normals = {pending_normals, vertex_normal(it.index)};
        end
    endtask

    task automatic store_vertex(input int idx, input int x, input int y, input int z);
        in_item_t it;
        it.action = ACT_STORE;
        it.index  = IDX_W'(idx);
        it.pos_x  = FIELD_W'(x);
        it.pos_y  = FIELD_W'(y);
        it.pos_z  = FIELD_W'(z);
        send_request(it);
    endtask

    task automatic query_vertex(input int idx);
        in_item_t it;
        it.action = ACT_QUERY;
        it.index  = IDX_W'(idx);
        // position fields are don't-care
        it.pos_x  = FIELD_W'($urandom);
        it.pos_y  = FIELD_W'($urandom);
        it.pos_z  = FIELD_W'($urandom);
        send_request(it);
    endtask

    // drop valid, wait for outstanding normals, then let the block settle
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (pending_normals.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    task automatic reg_write(input logic regsel, input int val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {regsel, 2'b00};
        pwdata  <= 32'(val);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (regsel == REG_ROW_LENGTH) cur_row_len = val & 16'h3FFF;
        else                          cur_vert_cnt = val & 16'h3FFF;
    endtask

    task automatic set_grid(input int n, input int vc);
        wait_idle();
        reg_write(REG_ROW_LENGTH, n);
        reg_write(REG_VERTEX_COUNT, vc);
    endtask

    function automatic int rand_coord();
        case ($urandom_range(9))
            0:       return 8388607;
            1:       return -8388608;
            2:       return 0;
            3:       return $urandom_range(512) - 256;
            default: return int'(FIELD_W'($urandom));
        endcase
    endfunction

    // ---------------------------------------------------------------------
    // Result side
    // ---------------------------------------------------------------------
    always @(posedge aclk) begin
        m_ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 12);
    end

    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_normals.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("unexpected result: idx %0d n (%0d %0d %0d) slope %0d",
                             m_data.vertex_index, m_data.normal_x, m_data.normal_y,
                             m_data.normal_z, m_data.slope);
            end else begin
                want = pending_normals.pop_front();
                if (m_data.vertex_index !== want.vertex_index ||
                    m_data.normal_x !== want.normal_x || m_data.normal_y !== want.normal_y ||
                    m_data.normal_z !== want.normal_z || m_data.slope !== want.slope) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("mismatch: exp idx %0d n (%0d %0d %0d) slope %0d, got idx %0d n (%0d %0d %0d) slope %0d",
                                 want.vertex_index, want.normal_x, want.normal_y,
                                 want.normal_z, want.slope, m_data.vertex_index,
                                 m_data.normal_x, m_data.normal_y, m_data.normal_z,
                                 m_data.slope);
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------------

    // 3x3 patch with extreme coordinates; center, corner and far corner queried
    task automatic test_extreme_patch();
        set_grid(3, 9);
        store_vertex(0, 8388607, 0, -8388608);
        store_vertex(1, -8388608, 8388607, 0);
        store_vertex(2, 0, -8388608, 8388607);
        store_vertex(3, 256, 512, -256);
        store_vertex(4, 0, 0, 0);
        store_vertex(5, -1, 1, -1);
        store_vertex(6, 8388607, 8388607, 8388607);
        store_vertex(7, -8388608, -8388608, -8388608);
        store_vertex(8, 1000, -70000, 3);
        query_vertex(4);
        query_vertex(0);
        query_vertex(8);
    endtask

    // no neighbours (zero sum), query beyond vertex_count, degenerate rows
    task automatic test_corner_cases();
        set_grid(3, 1);
        query_vertex(0);            // every pair out of range: zero normal
        set_grid(3, 0);
        store_vertex(8191, 100, 200, 300);
        query_vertex(8191);         // beyond vertex_count and top of the index range
        set_grid(1, 9);
        query_vertex(4);            // row length 1: several pairs collapse
        set_grid(0, 9);
        query_vertex(4);            // row length 0: every triangle degenerate
        set_grid(16383, 16383);
        query_vertex(4);            // widest settings, no pair fully in range
    endtask

    // one random phase: fill the low window, then mixed stores and queries
    task automatic run_phase(input int n, input int vc, input int cnt, input bit quiet);
        int win, idx;
        set_grid(n, vc);
        no_idle = quiet;
        win = (vc < 72) ? ((vc < 1) ? 1 : vc) : 72;
        for (int i = 0; i < win; i++)
            if (!grid_seen[i]) store_vertex(i, rand_coord(), rand_coord(), rand_coord());
        for (int i = 0; i < cnt; i++) begin
            if ($urandom_range(9) == 0) idx = $urandom_range(STORE_DEPTH - 1);
            else                        idx = $urandom_range(win - 1);
            if ($urandom_range(99) < 45 && query_safe(idx)) query_vertex(idx);
            else store_vertex(idx, rand_coord(), rand_coord(), rand_coord());
        end
        no_idle = 1'b0;
    endtask

    task automatic test_random_grids();
        run_phase(8, 64, 130, 1'b0);
        run_phase(5, 40, 130, 1'b1);   // no stalls on either side
        run_phase(2, 30, 120, 1'b0);
        run_phase(8192, 8192, 110, 1'b0);
        run_phase(65, 4225, 110, 1'b0);
        run_phase(7, 50, 130, 1'b0);
        run_phase(2, 8192, 110, 1'b0);
    endtask

    initial begin
        cur_row_len  = ROW_LENGTH_RST;
        cur_vert_cnt = VERTEX_COUNT_RST;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_extreme_patch();
        test_corner_cases();
        test_random_grids();
        wait_idle();
        if (mismatch_cnt == 0 && pending_normals.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
